/* src/rivl_pkg.sv */
// Package for the record image view lookup block.
// Holds the transaction structs, status and register codes and stream constants.
// No dependencies.
`timescale 1ns / 1ps

package rivl_pkg;

  // Image layout
  localparam int MaxRecords  = 64;
  localparam int RecordBytes = 24;
  localparam int HeaderBytes = 8;

  // The byte counter stops one past the largest legal image length
  localparam int LenCap  = HeaderBytes + MaxRecords * RecordBytes + 1;
  localparam int CntW    = $clog2(LenCap + 1);
  localparam int RecNumW = $clog2(MaxRecords + 1);

  // Header byte positions
  localparam int MagicBytes = 4;
  localparam int VerLoPos   = 4;
  localparam int VerHiPos   = 5;
  localparam int CountLoPos = 6;
  localparam int CountHiPos = 7;

  // Offsets within one record
  localparam int KindOff      = 0;
  localparam int DirLoOff     = 2;
  localparam int DirHiOff     = 3;
  localparam int FieldsLoOff  = 17;
  localparam int FieldsHiOff  = 22;
  localparam int RecLastOff   = RecordBytes - 1;

  // Magic "IDB1", entry 0 first on the stream
  localparam logic [MagicBytes-1:0][7:0] Magic = {8'h31, 8'h42, 8'h44, 8'h49};

  typedef enum logic [2:0] {
    StatusOk       = 3'd0,
    StatusLenErr   = 3'd1,
    StatusBadMagic = 3'd2,
    StatusBadVer   = 3'd3,
    StatusCountBig = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    RegTargetDir       = 2'd0,
    RegExpectedVersion = 2'd1,
    RegViewKind        = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        found;
    logic [5:0]  record_index;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] view_flags;
  } out_item_t;

endpackage

/* src/record_image_view_lookup_core.sv */
// Record image view lookup: header check and view record search over a byte stream.
// Depends on rivl_pkg (structs, status and register codes, layout constants).
`timescale 1ns / 1ps

// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+--------------------------------
// in        | sink      | in_valid_i / in_stall_o    | in_item_t: byte_value, last_byte
// out       | source    | out_valid_o / out_stall_i  | out_item_t: status .. view_flags
// cfg       | sink      | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One byte per clock while the input is not stalled. Each byte updates the stream state
// on the edge it is taken; on the final byte the result is formed from the updated state
// in the same cycle and lands in the output register, so it appears in the cycle after
// the last byte. The input stalls only while a result sits in the output register and
// the sink stalls it. Reset initialises config, stream state and output valid at once,
// but not the output payload: no clearing pass. The config port never stalls.

module record_image_view_lookup_core
  import rivl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte stream
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  // results
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o,
  // register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  // Configuration registers
  logic [15:0] target_dir_q;
  logic [15:0] exp_ver_q;
  logic [7:0]  view_kind_q;

  // Stream state
  logic [CntW-1:0]    byte_cnt_q,   byte_cnt_d,   byte_cnt_u;
  logic               magic_ok_q,   magic_ok_d,   magic_ok_u;
  logic [15:0]        ver_word_q,   ver_word_d,   ver_word_u;
  logic [15:0]        cnt_word_q,   cnt_word_d,   cnt_word_u;
  logic [4:0]         rec_off_q,    rec_off_d,    rec_off_u;
  logic [RecNumW-1:0] rec_num_q,    rec_num_d,    rec_num_u;
  logic               cur_match_q,  cur_match_d,  cur_match_u;
  logic [7:0]         cur_dir_lo_q, cur_dir_lo_d, cur_dir_lo_u;
  logic [47:0]        cur_fields_q, cur_fields_d, cur_fields_u;
  logic               hit_q,        hit_d,        hit_u;
  logic [47:0]        hit_fields_q, hit_fields_d, hit_fields_u;
  logic [RecNumW-1:0] hit_idx_q,    hit_idx_d,    hit_idx_u;

  // Output register
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q,  out_item_d;

  logic        in_accept;
  logic [7:0]  in_byte;
  logic [2:0]  lane;
  status_e     status;
  logic        found;
  logic [CntW-1:0] exp_len;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign in_byte     = in_item_i.byte_value;
  assign lane        = 3'(rec_off_q - 5'(FieldsLoOff));
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Register writes; unknown index is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_dir_q <= 16'd0;
      exp_ver_q    <= 16'd1;
      view_kind_q  <= 8'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegTargetDir:       target_dir_q <= cfg_data_i;
        RegExpectedVersion: exp_ver_q    <= cfg_data_i;
        RegViewKind:        view_kind_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Stream state after taking the current byte
  always_comb begin
    byte_cnt_u   = byte_cnt_q;
    magic_ok_u   = magic_ok_q;
    ver_word_u   = ver_word_q;
    cnt_word_u   = cnt_word_q;
    rec_off_u    = rec_off_q;
    rec_num_u    = rec_num_q;
    cur_match_u  = cur_match_q;
    cur_dir_lo_u = cur_dir_lo_q;
    cur_fields_u = cur_fields_q;
    hit_u        = hit_q;
    hit_fields_u = hit_fields_q;
    hit_idx_u    = hit_idx_q;

    // Saturated counter: overlong tail is ignored
    if (byte_cnt_q < CntW'(LenCap)) begin
      byte_cnt_u = byte_cnt_q + 1'b1;
      priority if (byte_cnt_q < CntW'(MagicBytes)) begin
        if (in_byte != Magic[byte_cnt_q[1:0]]) begin
          magic_ok_u = 1'b0;
        end
      end else if (byte_cnt_q == CntW'(VerLoPos)) begin
        ver_word_u[7:0] = in_byte;
      end else if (byte_cnt_q == CntW'(VerHiPos)) begin
        ver_word_u[15:8] = in_byte;
      end else if (byte_cnt_q == CntW'(CountLoPos)) begin
        cnt_word_u[7:0] = in_byte;
      end else if (byte_cnt_q == CntW'(CountHiPos)) begin
        cnt_word_u[15:8] = in_byte;
      end else if (rec_num_q < RecNumW'(MaxRecords)) begin
        priority if (rec_off_q == 5'(KindOff)) begin
          cur_match_u  = (in_byte == view_kind_q);
          cur_fields_u = 48'd0;
        end else if (rec_off_q == 5'(DirLoOff)) begin
          cur_dir_lo_u = in_byte;
        end else if (rec_off_q == 5'(DirHiOff)) begin
          cur_match_u = cur_match_q & ({in_byte, cur_dir_lo_q} == target_dir_q);
        end else if (rec_off_q >= 5'(FieldsLoOff) && rec_off_q <= 5'(FieldsHiOff)) begin
          cur_fields_u[lane*8 +: 8] = cur_fields_q[lane*8 +: 8] | in_byte;
        end else if (rec_off_q == 5'(RecLastOff)) begin
          // first match wins
          if (cur_match_q && !hit_q) begin
            hit_u        = 1'b1;
            hit_fields_u = cur_fields_q;
            hit_idx_u    = rec_num_q;
          end
        end else begin
        end

        if (rec_off_q == 5'(RecLastOff)) begin
          rec_off_u = 5'd0;
          rec_num_u = rec_num_q + 1'b1;
        end else begin
          rec_off_u = rec_off_q + 5'd1;
        end
      end else begin
      end
    end
  end

  // Final status, checks in header order; count is bounded before the length product
  assign exp_len = CntW'(HeaderBytes) + CntW'(cnt_word_u[RecNumW-1:0]) * CntW'(RecordBytes);

  always_comb begin
    priority if (byte_cnt_u < CntW'(HeaderBytes)) begin
      status = StatusLenErr;
    end else if (!magic_ok_u) begin
      status = StatusBadMagic;
    end else if (ver_word_u != exp_ver_q) begin
      status = StatusBadVer;
    end else if (cnt_word_u > 16'(MaxRecords)) begin
      status = StatusCountBig;
    end else if (exp_len != byte_cnt_u) begin
      status = StatusLenErr;
    end else begin
      status = StatusOk;
    end
  end

  assign found = (status == StatusOk) & hit_u;

  always_comb begin
    out_item_d.status       = status;
    out_item_d.found        = found;
    out_item_d.record_index = found ? 6'(hit_idx_u)       : 6'd0;
    out_item_d.pos_x        = found ? hit_fields_u[15:0]  : 16'd0;
    out_item_d.pos_y        = found ? hit_fields_u[31:16] : 16'd0;
    out_item_d.view_flags   = found ? hit_fields_u[47:32] : 16'd0;
  end

  // Next state: hold when idle, clear after the final byte
  always_comb begin
    byte_cnt_d   = byte_cnt_q;
    magic_ok_d   = magic_ok_q;
    ver_word_d   = ver_word_q;
    cnt_word_d   = cnt_word_q;
    rec_off_d    = rec_off_q;
    rec_num_d    = rec_num_q;
    cur_match_d  = cur_match_q;
    cur_dir_lo_d = cur_dir_lo_q;
    cur_fields_d = cur_fields_q;
    hit_d        = hit_q;
    hit_fields_d = hit_fields_q;
    hit_idx_d    = hit_idx_q;
    if (in_accept) begin
      if (in_item_i.last_byte) begin
        byte_cnt_d   = '0;
        magic_ok_d   = 1'b1;
        ver_word_d   = 16'd0;
        cnt_word_d   = 16'd0;
        rec_off_d    = 5'd0;
        rec_num_d    = '0;
        cur_match_d  = 1'b0;
        cur_dir_lo_d = 8'd0;
        cur_fields_d = 48'd0;
        hit_d        = 1'b0;
        hit_fields_d = 48'd0;
        hit_idx_d    = '0;
      end else begin
        byte_cnt_d   = byte_cnt_u;
        magic_ok_d   = magic_ok_u;
        ver_word_d   = ver_word_u;
        cnt_word_d   = cnt_word_u;
        rec_off_d    = rec_off_u;
        rec_num_d    = rec_num_u;
        cur_match_d  = cur_match_u;
        cur_dir_lo_d = cur_dir_lo_u;
        cur_fields_d = cur_fields_u;
        hit_d        = hit_u;
        hit_fields_d = hit_fields_u;
        hit_idx_d    = hit_idx_u;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q   <= '0;
      magic_ok_q   <= 1'b1;
      ver_word_q   <= 16'd0;
      cnt_word_q   <= 16'd0;
      rec_off_q    <= 5'd0;
      rec_num_q    <= '0;
      cur_match_q  <= 1'b0;
      cur_dir_lo_q <= 8'd0;
      cur_fields_q <= 48'd0;
      hit_q        <= 1'b0;
      hit_fields_q <= 48'd0;
      hit_idx_q    <= '0;
    end else begin
      byte_cnt_q   <= byte_cnt_d;
      magic_ok_q   <= magic_ok_d;
      ver_word_q   <= ver_word_d;
      cnt_word_q   <= cnt_word_d;
      rec_off_q    <= rec_off_d;
      rec_num_q    <= rec_num_d;
      cur_match_q  <= cur_match_d;
      cur_dir_lo_q <= cur_dir_lo_d;
      cur_fields_q <= cur_fields_d;
      hit_q        <= hit_d;
      hit_fields_q <= hit_fields_d;
      hit_idx_q    <= hit_idx_d;
    end
  end

  // Output register: loads on the final byte, empties when the sink takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_accept && in_item_i.last_byte) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && in_item_i.last_byte) begin
      out_item_q <= out_item_d;
    end
  end

endmodule

/* verif/rivl_view_lookup_sb.sv */
// Scoreboard for the record image view lookup testbench: register shadow,
// image predictor and the queue of pending lookup results.
// Depends on rivl_pkg (structs, status and register codes, layout constants).
`timescale 1ns / 1ps

package rivl_view_lookup_tb_pkg;
  import rivl_pkg::*;

  class view_lookup_scoreboard;
    // register shadow
    bit [15:0] target_dir;
    bit [15:0] expected_version;
    bit [7:0]  view_kind;

    // per-image state
    bit [CntW-1:0]    byte_count;
    bit               magic_ok;
    bit [15:0]        version_word;
    bit [15:0]        count_word;
    bit [4:0]         rec_offset;
    bit [RecNumW-1:0] rec_number;
    bit               cur_match;
    bit [7:0]         cur_dir_lo;
    bit [47:0]        cur_fields;
    bit               hit;
    bit [47:0]        hit_fields;
    bit [5:0]         hit_index;

    out_item_t   expected_lookups[$];
    int unsigned mismatches;

    function new();
      target_dir       = '0;
      expected_version = 16'd1;
      view_kind        = '0;
      mismatches       = 0;
      clear_image();
    endfunction

    function void clear_image();
      byte_count   = '0;
      magic_ok     = 1'b1;
      version_word = '0;
      count_word   = '0;
      rec_offset   = '0;
      rec_number   = '0;
      cur_match    = 1'b0;
      cur_dir_lo   = '0;
      cur_fields   = '0;
      hit          = 1'b0;
      hit_fields   = '0;
      hit_index    = '0;
    endfunction

    function void write_register(logic [1:0] idx, logic [15:0] data);
      case (idx)
        RegTargetDir:       target_dir = data;
        RegExpectedVersion: expected_version = data;
        RegViewKind:        view_kind = data[7:0];
        default: ;
      endcase
    endfunction

    // Fold one accepted byte into the image state; on the final byte queue the lookup.
    function void note_byte(in_item_t item);
      bit [7:0]  b;
      status_e   st;
      out_item_t res;
      b = item.byte_value;
      if (byte_count < LenCap) begin
        if (byte_count < MagicBytes) begin
          if (b != Magic[byte_count]) magic_ok = 1'b0;
        end else if (byte_count == VerLoPos) begin
          version_word[7:0] = b;
        end else if (byte_count == VerHiPos) begin
          version_word[15:8] = b;
        end else if (byte_count == CountLoPos) begin
          count_word[7:0] = b;
        end else if (byte_count == CountHiPos) begin
          count_word[15:8] = b;
        end else if (rec_number < MaxRecords) begin
          if (rec_offset == KindOff) begin
            cur_match  = (b == view_kind);
            cur_fields = '0;
          end else if (rec_offset == DirLoOff) begin
            cur_dir_lo = b;
          end else if (rec_offset == DirHiOff) begin
            cur_match = cur_match && ({b, cur_dir_lo} == target_dir);
          end else if (rec_offset >= FieldsLoOff && rec_offset <= FieldsHiOff) begin
            cur_fields[(rec_offset - FieldsLoOff) * 8 +: 8] = b;
          end else if (rec_offset == RecLastOff) begin
            if (cur_match && !hit) begin
              hit        = 1'b1;
              hit_fields = cur_fields;
              hit_index  = rec_number[5:0];
            end
          end
          if (rec_offset == RecLastOff) begin
            rec_offset = '0;
            rec_number++;
          end else begin
            rec_offset++;
          end
        end
        byte_count++;
      end
      if (!item.last_byte) return;

      if (byte_count < HeaderBytes) st = StatusLenErr;
      else if (!magic_ok) st = StatusBadMagic;
      else if (version_word != expected_version) st = StatusBadVer;
      else if (count_word > MaxRecords) st = StatusCountBig;
      else if (HeaderBytes + count_word * RecordBytes != byte_count) st = StatusLenErr;
      else st = StatusOk;

      res = '0;
      res.status = st;
      if (st == StatusOk && hit) begin
        res.found        = 1'b1;
        res.record_index = hit_index;
        res.pos_x        = hit_fields[15:0];
        res.pos_y        = hit_fields[31:16];
        res.view_flags   = hit_fields[47:32];
      end
      expected_lookups.push_back(res);
      clear_image();
    endfunction

    task report(string msg);
      if (mismatches < 40) $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_lookups.size() == 0) begin
        report("lookup result with no image pending");
        return;
      end
      want = expected_lookups.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.found !== want.found)
        report($sformatf("found %0b, want %0b", got.found, want.found));
      if (got.record_index !== want.record_index)
        report($sformatf("record_index %0d, want %0d", got.record_index, want.record_index));
      if (got.pos_x !== want.pos_x)
        report($sformatf("pos_x %h, want %h", got.pos_x, want.pos_x));
      if (got.pos_y !== want.pos_y)
        report($sformatf("pos_y %h, want %h", got.pos_y, want.pos_y));
      if (got.view_flags !== want.view_flags)
        report($sformatf("view_flags %h, want %h", got.view_flags, want.view_flags));
    endtask
  endclass

endpackage

/* verif/record_image_view_lookup_core_test.sv */
// Testbench for record_image_view_lookup_core: directed and random record images,
// checked transaction by transaction against a scoreboard predictor.
// Depends on rivl_pkg and rivl_view_lookup_tb_pkg (scoreboard).
`timescale 1ns / 1ps

module record_image_view_lookup_core_test;
  import rivl_pkg::*;
  import rivl_view_lookup_tb_pkg::*;

  localparam int QuietLimit   = 4000;  // cycles with no transaction on any channel
  localparam int SettleCycles = 8;     // result lands in the cycle after the last byte
  localparam int PhaseBytes   = 325;   // random byte budget per random phase

  // beyond the register list: the block must ignore it
  localparam logic [1:0] RegSpare = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_item_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_item_t   out_item_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  view_lookup_scoreboard sb;
  bit [7:0]    image_bytes[$];   // image being built, sent byte by byte
  int          send_idle_pct;
  int          stall_pct;
  int unsigned quiet_cycles = 0;

  record_image_view_lookup_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Sink side: random stall at the rate of the current phase.
  always @(posedge clk_i) begin
    out_stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Every accepted result transaction goes to the scoreboard. Values read here
  // are the ones present before the edge, i.e. those the block acted on.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_item_o);
  end

  // Watchdog: counts edges at which no channel moves a transaction.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    do @(posedge clk_i); while (quiet_cycles < QuietLimit);
    $display("watchdog: no transaction for %0d cycles", QuietLimit);
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- image building

  function automatic void start_header(bit [15:0] version, bit [15:0] count);
    image_bytes.delete();
    for (int i = 0; i < MagicBytes; i++) image_bytes.push_back(Magic[i]);
    image_bytes.push_back(version[7:0]);
    image_bytes.push_back(version[15:8]);
    image_bytes.push_back(count[7:0]);
    image_bytes.push_back(count[15:8]);
  endfunction

  // kind at +0, directory word at +2, 13-byte name from +4, x/y/view words from +17
  function automatic void add_record(bit [7:0] kind, bit [15:0] dir, bit [47:0] fields);
    image_bytes.push_back(kind);
    image_bytes.push_back(8'($urandom));
    image_bytes.push_back(dir[7:0]);
    image_bytes.push_back(dir[15:8]);
    repeat (13) image_bytes.push_back(8'($urandom));
    for (int i = 0; i < 6; i++) image_bytes.push_back(fields[i*8 +: 8]);
    image_bytes.push_back(8'($urandom));
  endfunction

  function automatic bit [47:0] random_fields();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Mix of full matches, near misses on kind or directory, and random records.
  function automatic void add_random_record();
    bit [7:0]  kind;
    bit [15:0] dir;
    case ($urandom_range(3))
      0: begin
        kind = sb.view_kind;
        dir  = sb.target_dir;
      end
      1: begin
        kind = sb.view_kind;
        dir  = sb.target_dir ^ 16'($urandom_range(1, 65535));
      end
      2: begin
        kind = sb.view_kind ^ 8'($urandom_range(1, 255));
        dir  = sb.target_dir;
      end
      default: begin
        kind = 8'($urandom);
        dir  = 16'($urandom);
      end
    endcase
    add_record(kind, dir, random_fields());
  endfunction

  // ---------------------------------------------------------------- driving

  // Sends image_bytes, one input transaction per byte, the final one marked.
  // Valid is not dropped at the end so back-to-back images run without a gap.
  task automatic send_image();
    for (int i = 0; i < image_bytes.size(); i++) begin
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_item_i  <= '{byte_value: image_bytes[i], last_byte: (i == image_bytes.size() - 1)};
      do @(posedge clk_i); while (in_stall_o);
      sb.note_byte(in_item_i);
    end
  endtask

  // Stop sending and wait until every lookup has come back, plus a margin.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.expected_lookups.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes all three registers, then the unused index with junk. Upper data
  // bits of the view kind write carry junk too, which must be dropped.
  task automatic set_config(input logic [15:0] target, input logic [15:0] version,
                            input logic [7:0] kind);
    logic [1:0]  idx[4];
    logic [15:0] val[4];
    idx[0] = RegTargetDir;
    idx[1] = RegExpectedVersion;
    idx[2] = RegViewKind;
    idx[3] = RegSpare;
    val[0] = target;
    val[1] = version;
    val[2] = {8'($urandom), kind};
    val[3] = 16'($urandom);
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.write_register(idx[i], val[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------- stimulus

  // Runs on reset register values: target 0, version 1, view kind 0.
  task automatic run_directed();
    // shorter than the header
    image_bytes.delete();
    image_bytes.push_back(8'h49);
    send_image();
    start_header(sb.expected_version, 16'd0);
    void'(image_bytes.pop_back());
    send_image();

    // empty table, clean
    start_header(sb.expected_version, 16'd0);
    send_image();

    // one bad magic byte at each position
    for (int p = 0; p < MagicBytes; p++) begin
      start_header(sb.expected_version, 16'd0);
      image_bytes[p] = image_bytes[p] ^ 8'h80;
      send_image();
    end

    // bad magic wins over bad version; bad version wins over bad count
    start_header(~sb.expected_version, 16'd0);
    image_bytes[0] = 8'h00;
    send_image();
    start_header(16'hFFFF, 16'd65);
    send_image();

    // count above the maximum, including the largest count field
    start_header(sb.expected_version, 16'd65);
    send_image();
    start_header(sb.expected_version, 16'hFFFF);
    add_record(sb.view_kind, sb.target_dir, random_fields());
    send_image();

    // matching record but short of the stated count: no hit reported
    start_header(sb.expected_version, 16'd2);
    add_record(sb.view_kind, sb.target_dir, random_fields());
    send_image();

    // near miss on the directory high byte, then two matches: the first wins
    start_header(sb.expected_version, 16'd3);
    add_record(sb.view_kind, sb.target_dir ^ 16'h0100, random_fields());
    add_record(sb.view_kind, sb.target_dir, 48'hFFFF_FFFF_FFFF);
    add_record(sb.view_kind, sb.target_dir, 48'h0);
    send_image();

    // near misses on the directory low byte and on the kind: nothing found
    start_header(sb.expected_version, 16'd2);
    add_record(sb.view_kind, sb.target_dir ^ 16'h0001, random_fields());
    add_record(sb.view_kind ^ 8'h01, sb.target_dir, random_fields());
    send_image();

    // full table, only the last record matches
    start_header(sb.expected_version, 16'(MaxRecords));
    repeat (MaxRecords - 1)
      add_record(sb.view_kind ^ 8'h01, 16'($urandom), random_fields());
    add_record(sb.view_kind, sb.target_dir, random_fields());
    send_image();

    // overlong stream: counter saturates, length error
    start_header(sb.expected_version, 16'(MaxRecords));
    repeat (MaxRecords) add_random_record();
    repeat (20) image_bytes.push_back(8'($urandom));
    send_image();
  endtask

  // Mostly well-formed images with random records; the rest broken or noise.
  task automatic send_random_images(int unsigned budget);
    int unsigned sent;
    int unsigned pick;
    int unsigned recs;
    int unsigned keep;
    bit [15:0]   hdr_version;
    bit [15:0]   hdr_count;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(99);
      recs = ($urandom_range(99) < 85) ? $urandom_range(0, 4) : $urandom_range(5, 16);
      if (pick >= 95) begin
        image_bytes.delete();
        repeat ($urandom_range(1, 40)) image_bytes.push_back(8'($urandom));
      end else begin
        hdr_version = sb.expected_version;
        hdr_count   = 16'(recs);
        if (pick >= 84 && pick <= 89) hdr_version ^= 16'($urandom_range(1, 65535));
        if (pick >= 90) begin
          hdr_count = 16'($urandom_range(MaxRecords + 1, 65535));
          recs      = $urandom_range(0, 2);
        end
        start_header(hdr_version, hdr_count);
        repeat (recs) add_random_record();
        if (pick >= 65 && pick <= 71) begin
          // cut short anywhere, header included
          keep = $urandom_range(1, image_bytes.size() - 1);
          while (image_bytes.size() > keep) void'(image_bytes.pop_back());
        end else if (pick >= 72 && pick <= 77) begin
          // one record too many, or a few stray bytes
          if ($urandom_range(1)) add_random_record();
          else repeat ($urandom_range(1, 30)) image_bytes.push_back(8'($urandom));
        end else if (pick >= 78 && pick <= 83) begin
          keep = $urandom_range(0, MagicBytes - 1);
          image_bytes[keep] = image_bytes[keep] ^ 8'($urandom_range(1, 255));
        end
      end
      send_image();
      sent += image_bytes.size();
    end
  endtask

  initial begin
    sb            = new();
    send_idle_pct = 0;
    stall_pct     = 0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_item_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed images on reset register values, no idling
    run_directed();
    settle();

    // all-ones registers, no idling
    set_config(16'hFFFF, 16'hFFFF, 8'hFF);
    send_random_images(PhaseBytes);
    settle();

    // all-zero registers, sender idle most cycles
    set_config(16'h0000, 16'h0000, 8'h00);
    send_idle_pct = 78;
    send_random_images(PhaseBytes);
    settle();

    // random registers, sink stalling most cycles
    set_config(16'($urandom), 16'($urandom), 8'($urandom));
    send_idle_pct = 0;
    stall_pct     = 78;
    send_random_images(PhaseBytes);
    settle();

    // random registers, both sides idling
    set_config(16'($urandom), 16'($urandom), 8'($urandom));
    send_idle_pct = 38;
    stall_pct     = 38;
    send_random_images(PhaseBytes);
    settle();

    if (sb.mismatches == 0 && sb.expected_lookups.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
